// File: rtl/assert_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define MBC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds through reset.
`define MBC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// File: rtl/mbc_pkg.sv
// ----------------------------------------------------------------------------
// mbc_pkg
// Types, constants and the round function of the Magma block cipher unit.
// ----------------------------------------------------------------------------
package mbc_pkg;

   localparam int NUM_ROUNDS  = 32;
   localparam int NUM_SUBKEYS = 8;
   localparam int NUM_ROWS    = 8;
   localparam int ENC_FORWARD = 24;  // encrypt: K0..K7 thrice, then reversed
   localparam int DEC_FORWARD = 8;   // decrypt: K0..K7 once, then reversed
   localparam int ROTATE      = 11;

   localparam int REQ_TDATA_W = 136;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      OP_ENCRYPT = 2'd0,
      OP_DECRYPT = 2'd1,
      OP_LOAD    = 2'd2
   } mbc_op_type;

   typedef logic [NUM_ROWS-1:0][63:0]    mbc_rows_type;
   typedef logic [NUM_SUBKEYS-1:0][31:0] mbc_keys_type;

   typedef struct packed {
      mbc_op_type  op;
      logic [31:0] l;
      logic [31:0] r;
   } mbc_pay_type;

   typedef struct packed {
      logic        valid;
      mbc_pay_type pay;
   } mbc_word_type;

   // add key, substitute nibbles (top nibble through row 0), rotate left
   function automatic logic [31:0] mbc_round_f(logic [31:0] half, logic [31:0] key,
                                               mbc_rows_type rows);
      logic [31:0] sum;
      logic [31:0] acc;
      logic [3:0]  nib;
      sum = half + key;
      acc = '0;
      for (int i = 0; i < NUM_ROWS; i++) begin
         nib = sum[28-4*i +: 4];
         acc[28-4*i +: 4] = rows[i][{nib, 2'b00} +: 4];
      end
      return {acc[31-ROTATE:0], acc[31:32-ROTATE]};
   endfunction

   function automatic logic [2:0] mbc_enc_key_idx(logic [4:0] round);
      return (round < 5'(ENC_FORWARD)) ? round[2:0] : ~round[2:0];
   endfunction

   function automatic logic [2:0] mbc_dec_key_idx(logic [4:0] round);
      return (round < 5'(DEC_FORWARD)) ? round[2:0] : ~round[2:0];
   endfunction

endpackage

// File: rtl/mbc_state_regs.sv
// ----------------------------------------------------------------------------
// mbc_state_regs
// Subkey registers and substitution rows.
// ----------------------------------------------------------------------------
module mbc_state_regs import mbc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic                   row_wen,
   input  logic [2:0]             row_index,
   input  logic [63:0]            row_data,
   output mbc_keys_type           subkeys,
   output mbc_rows_type           rows
);

   mbc_keys_type keys_ff;
   mbc_rows_type rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else if (csr_wen) begin
         keys_ff[csr_index] <= csr_wdata;
      end
   end

   // rows hold no reset; they must be written before use, which this block does not enforce
   always_ff @(posedge clock) begin
      if (row_wen) begin
         rows_ff[row_index] <= row_data;
      end
   end

   assign subkeys = keys_ff;
   assign rows    = rows_ff;

endmodule

// File: rtl/mbc_round_cell.sv
// ----------------------------------------------------------------------------
// mbc_round_cell
// One Feistel round with its pipeline register and local flow control.
// ----------------------------------------------------------------------------
module mbc_round_cell import mbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mbc_word_type up_word,
   output logic         up_ready,
   input  logic [31:0]  enc_key,
   input  logic [31:0]  dec_key,
   input  mbc_rows_type rows,
   output mbc_word_type down_word,
   input  logic         down_ready
);

   logic        valid_ff;
   mbc_pay_type pay_ff;
   mbc_pay_type pay_in;

   // a bubble here can always be filled
   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      pay_in = up_word.pay;
      case (up_word.pay.op)
         OP_ENCRYPT: begin
            pay_in.l = up_word.pay.r;
            pay_in.r = up_word.pay.l ^ mbc_round_f(up_word.pay.r, enc_key, rows);
         end
         OP_DECRYPT: begin
            pay_in.l = up_word.pay.r ^ mbc_round_f(up_word.pay.l, dec_key, rows);
            pay_in.r = up_word.pay.l;
         end
         default: begin
            pay_in = up_word.pay;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         pay_ff <= pay_in;
      end
   end

   assign down_word = '{valid: valid_ff, pay: pay_ff};

endmodule

// File: rtl/magma_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// magma_block_cipher_unit
// Magma 64-bit block cipher, one round cell per round.
// ----------------------------------------------------------------------------
// A row of 32 round cells, one per round, carries each word from the request
// side to the response side: a cipher word is accepted every cycle while the
// response side keeps up, and its result passes through the 32 cell registers,
// the last cell being the output register.
// Cells stall locally, so bubbles close up while the response side waits.
// A row-load word writes its substitution row when accepted and is held off
// until no encrypt or decrypt word is left in the cells; it then travels the
// row like any word and returns zeros, in order. Subkeys are written through
// the csr port; the user must do so only while the unit is idle, which the
// block itself does not enforce.
module magma_block_cipher_unit import mbc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] left_in, [63:32] right_in, [66:64] row_index, [130:67] row_data
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] left_out, [63:32] right_out
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   mbc_word_type              words [NUM_ROUNDS+1];
   logic [NUM_ROUNDS:0]       ready;
   logic [NUM_ROUNDS-1:0]     busy_vec;
   logic                      cipher_busy;
   logic                      is_cipher;
   logic                      is_load;
   logic                      entry_ok;
   mbc_keys_type              subkeys;
   mbc_rows_type              rows;

   assign is_cipher = (req_tuser == OP_ENCRYPT) || (req_tuser == OP_DECRYPT);
   assign is_load   = (req_tuser == OP_LOAD);
   assign entry_ok  = !(is_load && cipher_busy);

   assign req_tready = ready[0] && entry_ok;

   assign words[0] = '{valid: req_tvalid && entry_ok,
                       pay:   '{op: mbc_op_type'(req_tuser),
                                l:  is_cipher ? req_tdata[31:0]  : '0,
                                r:  is_cipher ? req_tdata[63:32] : '0}};

   mbc_state_regs u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .row_wen   (req_tvalid && req_tready && is_load),
      .row_index (req_tdata[66:64]),
      .row_data  (req_tdata[130:67]),
      .subkeys   (subkeys),
      .rows      (rows)
   );

   for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
      mbc_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_word    (words[g]),
         .up_ready   (ready[g]),
         .enc_key    (subkeys[mbc_enc_key_idx(5'(g))]),
         .dec_key    (subkeys[mbc_dec_key_idx(5'(g))]),
         .rows       (rows),
         .down_word  (words[g+1]),
         .down_ready (ready[g+1])
      );
      assign busy_vec[g] = words[g+1].valid &&
                           ((words[g+1].pay.op == OP_ENCRYPT) ||
                            (words[g+1].pay.op == OP_DECRYPT));
   end

   assign cipher_busy = |busy_vec;

   assign ready[NUM_ROUNDS] = rsp_tready;
   assign rsp_tvalid        = words[NUM_ROUNDS].valid;
   assign rsp_tdata         = {words[NUM_ROUNDS].pay.r, words[NUM_ROUNDS].pay.l};

endmodule

// File: rtl/mbc_checker.sv
// ----------------------------------------------------------------------------
// mbc_checker
// Port-level checks for the Magma block cipher unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbc_checker import mbc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic rsp_wait;
   logic cipher_take;
   logic load_take;

   assign rsp_wait    = rsp_tvalid && !rsp_tready;
   assign cipher_take = req_tvalid && req_tready &&
                        ((req_tuser == OP_ENCRYPT) || (req_tuser == OP_DECRYPT));
   assign load_take   = req_tvalid && req_tready && (req_tuser == OP_LOAD);

   `MBC_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> rsp_tvalid, "rsp word dropped")
   `MBC_ASSERT(a_rsp_stable, clock, reset, rsp_wait |=> $stable(rsp_tdata), "rsp word changed")
   `MBC_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "rsp word after reset")
   // a row load must wait behind a cipher word still in the cells
   `MBC_ASSERT(a_load_waits, clock, reset, cipher_take |=> !load_take, "row load too early")

endmodule

bind magma_block_cipher_unit mbc_checker u_mbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
